// ===== design/tfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Temporal blur package
// Shared widths, weights, payload types and register indexes for the
// three-frame temporal blur block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfb_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int MAX_PIXELS   = 524288;
    localparam int ADDR_BITS    = $clog2(MAX_PIXELS);

    // Q0.8 weights for 0.5, 0.3 and 0.2
    localparam int WEIGHT_BITS = 8;
    localparam logic [WEIGHT_BITS-1:0] W_CUR  = WEIGHT_BITS'(128);
    localparam logic [WEIGHT_BITS-1:0] W_PREV = WEIGHT_BITS'(77);
    localparam logic [WEIGHT_BITS-1:0] W_OLD  = WEIGHT_BITS'(51);
    localparam int SUM_BITS = CHANNEL_BITS + WEIGHT_BITS;

    // History depth counter
    localparam logic [1:0] HIST_FULL = 2'd2;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // Configuration port
    localparam int CFG_DATA_BITS = 11;
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
        logic                    frame_end_in;
    } t_pix_in;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
        logic                    frame_end_out;
    } t_pix_out;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_rgb;

    // One history entry: pixel one frame back and two frames back
    typedef struct packed {
        t_rgb prev;
        t_rgb old;
    } t_hist;

    localparam int HIST_BITS = $bits(t_hist);

endpackage

// ===== design/three_frame_temporal_blur_top.sv =====
// ----------------------------------------------------------------------------
// Three-frame temporal blur, top level
// An accepted pixel passes the stage 1 registers (with the RAM read), then the output queue.
// Throughput 1 pixel per cycle while the input is not stalled: each pixel uses one RAM read and one RAM write.
// Reset: synchronous, active low; clears address, frame count and pipeline, and sets frame size to 640 by 480.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_frame_temporal_blur_top import tfb_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Pixel input
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_pix_in                  i_in_data,
    // Pixel output
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_pix_out                 o_out_data,
    // Register write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  t_cfg_index               i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Frame size registers. Stored for software; any write restarts the
    // history so the blend waits for two fresh frames.
    // ------------------------------------------------------------------
    logic [10:0] r_frame_width;
    logic [9:0]  r_frame_height;
    logic        w_cfg_write;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd640;
            r_frame_height <= 10'd480;
        end else if (w_cfg_write) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[9:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input transaction and pixel address / frame count
    // ------------------------------------------------------------------
    logic                     w_in_accept;
    logic [ADDR_BITS-1:0]     r_addr, n_addr;
    logic [1:0]               r_hist, n_hist;
    logic [FIFO_CNT_BITS-1:0] w_fifo_count;
    logic                     r_s1_valid;

    // Stall once the queue plus the item in flight could fill it; this
    // never depends on the output stall, so no combinational path crosses.
    assign o_in_stall  = ((FIFO_CNT_BITS+1)'(w_fifo_count) + (FIFO_CNT_BITS+1)'(r_s1_valid))
                         >= (FIFO_CNT_BITS+1)'(FIFO_DEPTH);
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_addr = r_addr;
        n_hist = r_hist;
        if (w_in_accept) begin
            if (i_in_data.frame_end_in) begin
                // Wrap to the first pixel and count one more stored frame
                n_addr = '0;
                if (r_hist != HIST_FULL) begin
                    n_hist = r_hist + 2'd1;
                end
            end else if (r_addr != ADDR_BITS'(MAX_PIXELS - 1)) begin
                n_addr = r_addr + ADDR_BITS'(1);
            end
        end
        // The user must write registers only while idle; the block does not enforce it. Clear the frame count
        if (w_cfg_write) begin
            n_hist = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_hist <= '0;
        end else begin
            r_addr <= n_addr;
            r_hist <= n_hist;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: history read returns; blend and write back.
    // The stage never stalls: the input stall reserves its queue slot.
    // ------------------------------------------------------------------
    logic                 r_s1_blend;
    logic                 r_s1_fwd;
    logic [ADDR_BITS-1:0] r_s1_addr;
    t_pix_in              r_s1_pix;
    t_hist                r_s1_fwd_data;
    t_hist                w_ram_q;
    t_hist                w_hist;
    t_hist                w_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_addr     <= r_addr;
            r_s1_pix      <= i_in_data;
            r_s1_blend    <= (r_hist == HIST_FULL);
            // Same address as the pixel writing back now: bypass the RAM
            r_s1_fwd      <= r_s1_valid && (r_s1_addr == r_addr);
            r_s1_fwd_data <= w_wr_data;
        end
    end

    tfb_hist_ram #(
        .DATA_BITS (HIST_BITS),
        .DEPTH     (MAX_PIXELS)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_in_accept),
        .i_rd_addr (r_addr),
        .o_rd_data (w_ram_q)
    );

    assign w_hist = r_s1_fwd ? r_s1_fwd_data : w_ram_q;

    // Shift the history: old <= prev, prev <= current
    always_comb begin
        w_wr_data.prev.red   = r_s1_pix.red_in;
        w_wr_data.prev.green = r_s1_pix.green_in;
        w_wr_data.prev.blue  = r_s1_pix.blue_in;
        w_wr_data.old        = w_hist.prev;
    end

    // ------------------------------------------------------------------
    // Color lanes and merge into one output pixel
    // ------------------------------------------------------------------
    t_pix_out w_result;

    tfb_lane u_lane_red (
        .i_cur   (r_s1_pix.red_in),
        .i_prev  (w_hist.prev.red),
        .i_old   (w_hist.old.red),
        .i_blend (r_s1_blend),
        .o_pix   (w_result.red_out)
    );

    tfb_lane u_lane_green (
        .i_cur   (r_s1_pix.green_in),
        .i_prev  (w_hist.prev.green),
        .i_old   (w_hist.old.green),
        .i_blend (r_s1_blend),
        .o_pix   (w_result.green_out)
    );

    tfb_lane u_lane_blue (
        .i_cur   (r_s1_pix.blue_in),
        .i_prev  (w_hist.prev.blue),
        .i_old   (w_hist.old.blue),
        .i_blend (r_s1_blend),
        .o_pix   (w_result.blue_out)
    );

    assign w_result.frame_end_out = r_s1_pix.frame_end_in;

    // ------------------------------------------------------------------
    // Output queue: hold finished pixels while the sink stalls
    // ------------------------------------------------------------------
    tfb_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_data (w_result),
        .i_pop       (o_out_valid && !i_out_stall),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data),
        .o_count     (w_fifo_count)
    );

endmodule

// ===== design/tfb_hist_ram.sv =====
// ----------------------------------------------------------------------------
// History RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfb_hist_ram #(
    parameter int DATA_BITS = 48,
    parameter int DEPTH     = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0]     i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0]     o_rd_data
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/tfb_lane.sv =====
// ----------------------------------------------------------------------------
// Blend lane
// Weighted three-tap sum of one color channel, truncated, or pass-through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfb_lane import tfb_pkg::*; (
    input  logic [CHANNEL_BITS-1:0] i_cur,
    input  logic [CHANNEL_BITS-1:0] i_prev,
    input  logic [CHANNEL_BITS-1:0] i_old,
    input  logic                    i_blend,
    output logic [CHANNEL_BITS-1:0] o_pix
);

    logic [SUM_BITS-1:0] w_sum;

    // Sum never exceeds 256 * max channel, so the top bits always fit
    assign w_sum = SUM_BITS'(W_CUR)  * SUM_BITS'(i_cur)
                 + SUM_BITS'(W_PREV) * SUM_BITS'(i_prev)
                 + SUM_BITS'(W_OLD)  * SUM_BITS'(i_old);

    assign o_pix = i_blend ? w_sum[SUM_BITS-1 -: CHANNEL_BITS] : i_cur;

endmodule

// ===== design/tfb_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Output queue
// Small register FIFO that holds finished pixels until the sink takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfb_out_fifo import tfb_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  t_pix_out                 i_push_data,
    input  logic                     i_pop,
    output logic                     o_valid,
    output t_pix_out                 o_data,
    output logic [FIFO_CNT_BITS-1:0] o_count
);

    t_pix_out                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + FIFO_PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + FIFO_PTR_BITS'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + FIFO_CNT_BITS'(1);
            2'b01:   n_count = r_count - FIFO_CNT_BITS'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== design/tfb_checker.sv =====
// ----------------------------------------------------------------------------
// Temporal blur port checker
// Watches the top-level ports for handshake, latency and reset behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfb_checker import tfb_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_pix_out o_out_data
);

    // A stalled output transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled output payload does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // Every accepted pixel is followed by a valid output once it has passed stage 1 and the queue
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> ##2 o_out_valid)
        else $error("accepted pixel did not reach the output");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind three_frame_temporal_blur_top tfb_checker u_tfb_checker (.*);
